/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RMQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// Next-cycle implication, checked outside reset.
`define RMQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

/* hw/rtl/rmq_pkg.sv */
`default_nettype none
package rmq_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    // which output slot carries the half root
    localparam logic [1:0] SEL_W = 2'd0;
    localparam logic [1:0] SEL_X = 2'd1;
    localparam logic [1:0] SEL_Y = 2'd2;
    localparam logic [1:0] SEL_Z = 2'd3;

    // control that travels with each word down the chain
    typedef struct packed {
        logic       valid;
        logic       bad;
        logic [1:0] sel;
        logic [2:0] neg;
    } ctl_t;

endpackage
`default_nettype wire

/* hw/rtl/rmq_mat_if.sv */
`default_nettype none
interface rmq_mat_if #(
    parameter int DW = 16
);
    logic valid;
    logic ready;
    logic [DW-1:0] m_r0c0;
    logic [DW-1:0] m_r0c1;
    logic [DW-1:0] m_r0c2;
    logic [DW-1:0] m_r1c0;
    logic [DW-1:0] m_r1c1;
    logic [DW-1:0] m_r1c2;
    logic [DW-1:0] m_r2c0;
    logic [DW-1:0] m_r2c1;
    logic [DW-1:0] m_r2c2;

    modport source (
        output valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
               m_r2c0, m_r2c1, m_r2c2,
        input  ready
    );
    modport sink (
        input  valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
               m_r2c0, m_r2c1, m_r2c2,
        output ready
    );
endinterface
`default_nettype wire

/* hw/rtl/rmq_quat_if.sv */
`default_nettype none
interface rmq_quat_if #(
    parameter int DW = 16
);
    logic valid;
    logic ready;
    logic [DW-1:0] quat_w;
    logic [DW-1:0] quat_x;
    logic [DW-1:0] quat_y;
    logic [DW-1:0] quat_z;
    logic          invalid;

    modport source (
        output valid, quat_w, quat_x, quat_y, quat_z, invalid,
        input  ready
    );
    modport sink (
        input  valid, quat_w, quat_x, quat_y, quat_z, invalid,
        output ready
    );
endinterface
`default_nettype wire

/* hw/rtl/rmq_front.sv */
`default_nettype none
module rmq_front #(
    parameter int DW  = 16,
    parameter int FB  = 14,
    parameter int AW  = 18,
    parameter int MW  = 17,
    parameter int XW2 = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [DW-1:0]         m [9],
    output rmq_pkg::ctl_t              ctl_reg,
    output logic [XW2-1:0]             x_reg,
    output logic [MW-1:0]              mag_reg [3]
);
    import rmq_pkg::*;

    localparam int ES = AW + 1;
    localparam logic signed [ES-1:0] ONE = ES'(1) << FB;

    logic signed [ES-1:0] d [3];
    logic signed [DW:0]   e [9];
    logic signed [ES-1:0] trace;
    logic signed [ES-1:0] arg;
    logic signed [DW:0]   num [3];
    logic                 tpos;
    logic [1:0]           pick;
    ctl_t                 ctl_next;
    logic [XW2-1:0]       x_next;
    logic [MW-1:0]        mag_next [3];

    // widen the elements
    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            e[k] = {m[k][DW-1], m[k]};
        end
        d[0] = {{(ES-DW){m[0][DW-1]}}, m[0]};
        d[1] = {{(ES-DW){m[4][DW-1]}}, m[4]};
        d[2] = {{(ES-DW){m[8][DW-1]}}, m[8]};
    end

    // pick branch, root argument and the three numerators
    always_comb
    begin
        trace = d[0] + d[1] + d[2];
        tpos  = trace > 0;
        pick  = 2'd0;
        if (d[1] > d[0])
        begin
            pick = 2'd1;
        end
        if (d[2] > d[pick])
        begin
            pick = 2'd2;
        end
        if (tpos)
        begin
            ctl_next.sel = SEL_W;
            arg    = trace + ONE;
            num[0] = e[7] - e[5];
            num[1] = e[2] - e[6];
            num[2] = e[3] - e[1];
        end
        else
        begin
            case (pick)
                2'd0:
                begin
                    ctl_next.sel = SEL_X;
                    arg    = d[0] - d[1] - d[2] + ONE;
                    num[0] = e[7] - e[5];
                    num[1] = e[3] + e[1];
                    num[2] = e[6] + e[2];
                end
                2'd1:
                begin
                    ctl_next.sel = SEL_Y;
                    arg    = d[1] - d[2] - d[0] + ONE;
                    num[0] = e[2] - e[6];
                    num[1] = e[7] + e[5];
                    num[2] = e[1] + e[3];
                end
                default:
                begin
                    ctl_next.sel = SEL_Z;
                    arg    = d[2] - d[0] - d[1] + ONE;
                    num[0] = e[3] - e[1];
                    num[1] = e[2] + e[6];
                    num[2] = e[5] + e[7];
                end
            endcase
        end
        ctl_next.valid = in_valid;
        ctl_next.bad   = arg <= 0;
        for (int k = 0; k < 3; k++)
        begin
            ctl_next.neg[k] = num[k][DW];
            mag_next[k]     = num[k][DW] ? MW'(-num[k]) : MW'(num[k]);
        end
        x_next = ctl_next.bad ? '0 : (XW2'(arg[AW-1:0]) << FB);
    end

    // hold control under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_next;
        end
    end

    // capture payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            mag_reg <= mag_next;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/rmq_sqrt_cell.sv */
`default_nettype none
module rmq_sqrt_cell #(
    parameter int SW  = 16,
    parameter int XW2 = 32,
    parameter int MW  = 17
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire rmq_pkg::ctl_t     ctl_in,
    input  wire logic [XW2-1:0]    x_in,
    input  wire logic [SW+1:0]     r_in,
    input  wire logic [SW-1:0]     q_in,
    input  wire logic [MW-1:0]     mag_in [3],
    output rmq_pkg::ctl_t          ctl_reg,
    output logic [XW2-1:0]         x_reg,
    output logic [SW+1:0]          r_reg,
    output logic [SW-1:0]          q_reg,
    output logic [MW-1:0]          mag_reg [3]
);
    import rmq_pkg::*;

    logic [SW+2:0] rs;
    logic [SW+2:0] trial;
    logic          ge;
    logic [SW+2:0] r_next;

    // one root bit: bring down two radicand bits and try the subtract
    always_comb
    begin
        rs     = {r_in[SW:0], x_in[XW2-1 -: 2]};
        trial  = {1'b0, q_in, 2'b01};
        ge     = rs >= trial;
        r_next = ge ? rs - trial : rs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_in << 2;
            r_reg   <= r_next[SW+1:0];
            q_reg   <= {q_in[SW-2:0], ge};
            mag_reg <= mag_in;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/rmq_div_cell.sv */
`default_nettype none
module rmq_div_cell #(
    parameter int NW = 32,
    parameter int SW = 16
) (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire logic [NW-1:0]  n_in,
    input  wire logic [SW+1:0]  r_in,
    input  wire logic [NW-1:0]  q_in,
    input  wire logic [SW:0]    d_in,
    output logic [NW-1:0]       n_reg,
    output logic [SW+1:0]       r_reg,
    output logic [NW-1:0]       q_reg
);
    logic [SW+1:0] rs;
    logic [SW+1:0] dd;
    logic          ge;

    // one quotient bit: shift in a dividend bit and try the subtract
    always_comb
    begin
        rs = {r_in[SW:0], n_in[NW-1]};
        dd = {1'b0, d_in};
        ge = rs >= dd;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg <= n_in << 1;
            r_reg <= ge ? rs - dd : rs;
            q_reg <= {q_in[NW-2:0], ge};
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/rotation_matrix_to_quaternion.sv */
// Rotation matrix to quaternion, one word per cycle while the output is not stalled, through a chain of bit cells.
// Path: front register, sqrt cells, divide stages, output register; SW = root bits, NW = quotient bits.
// Throughput: one word per cycle; one sqrt cell per root bit, one divide cell
// per quotient bit and lane, all advancing together; output stall holds the chain.
// Reset: asynchronous, active low; clears the valid bits, the chain comes up empty.
`default_nettype none
`include "assert_macros.svh"
module rotation_matrix_to_quaternion #(
    parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rmq_mat_if.sink    mat,
    rmq_quat_if.source quat
);
    import rmq_pkg::*;

    localparam int DW  = DATA_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int AW  = ((DW > FB) ? DW : FB + 1) + 2;
    localparam int XW  = AW + FB;
    localparam int SW  = (XW + 1) / 2;
    localparam int XW2 = 2 * SW;
    localparam int MW  = DW + 1;
    localparam int NW  = MW + FB + 1;
    localparam logic [NW-1:0] LIM = NW'(1) << (DW - 1);

    logic          en;
    logic [DW-1:0] m [9];

    // sqrt chain
    ctl_t           sq_ctl [0:SW];
    logic [XW2-1:0] sq_x   [0:SW];
    logic [SW+1:0]  sq_r   [0:SW];
    logic [SW-1:0]  sq_q   [0:SW];
    logic [MW-1:0]  sq_mag [0:SW][3];

    // divide chain
    ctl_t           dv_ctl  [0:NW];
    logic [SW-1:0]  dv_root [0:NW];
    logic [NW-1:0]  dv_n    [0:NW][3];
    logic [SW+1:0]  dv_r    [0:NW][3];
    logic [NW-1:0]  dv_q    [0:NW][3];

    logic [DW-1:0]  sat [3];
    logic [DW-1:0]  half;
    logic [SW:0]    half_sum;

    logic           out_valid_reg;
    logic [DW-1:0]  w_reg, x_reg, y_reg, z_reg;
    logic           bad_reg;
    logic [DW-1:0]  w_next, x_next, y_next, z_next;

    // advance the whole chain unless the output word is stuck
    assign en        = !out_valid_reg || quat.ready;
    assign mat.ready = en;

    assign m[0] = mat.m_r0c0;
    assign m[1] = mat.m_r0c1;
    assign m[2] = mat.m_r0c2;
    assign m[3] = mat.m_r1c0;
    assign m[4] = mat.m_r1c1;
    assign m[5] = mat.m_r1c2;
    assign m[6] = mat.m_r2c0;
    assign m[7] = mat.m_r2c1;
    assign m[8] = mat.m_r2c2;

    rmq_front #(.DW(DW), .FB(FB), .AW(AW), .MW(MW), .XW2(XW2)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (mat.valid),
        .m        (m),
        .ctl_reg  (sq_ctl[0]),
        .x_reg    (sq_x[0]),
        .mag_reg  (sq_mag[0])
    );
    assign sq_r[0] = '0;
    assign sq_q[0] = '0;

    genvar gs, gd, gl;
    generate
        for (gs = 0; gs < SW; gs++)
        begin : g_sqrt
            rmq_sqrt_cell #(.SW(SW), .XW2(XW2), .MW(MW)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .ctl_in  (sq_ctl[gs]),
                .x_in    (sq_x[gs]),
                .r_in    (sq_r[gs]),
                .q_in    (sq_q[gs]),
                .mag_in  (sq_mag[gs]),
                .ctl_reg (sq_ctl[gs+1]),
                .x_reg   (sq_x[gs+1]),
                .r_reg   (sq_r[gs+1]),
                .q_reg   (sq_q[gs+1]),
                .mag_reg (sq_mag[gs+1])
            );
        end

        // form the rounded dividends from the finished root
        assign dv_ctl[0]  = sq_ctl[SW];
        assign dv_root[0] = sq_q[SW];
        for (gl = 0; gl < 3; gl++)
        begin : g_lane0
            assign dv_n[0][gl] = (NW'(sq_mag[SW][gl]) << FB) + NW'(sq_q[SW]);
            assign dv_r[0][gl] = '0;
            assign dv_q[0][gl] = '0;
        end

        for (gd = 0; gd < NW; gd++)
        begin : g_div
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_ctl[gd+1] <= '0;
                end
                else if (en)
                begin
                    dv_ctl[gd+1] <= dv_ctl[gd];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_root[gd+1] <= dv_root[gd];
                end
            end

            for (gl = 0; gl < 3; gl++)
            begin : g_lane
                rmq_div_cell #(.NW(NW), .SW(SW)) u_cell (
                    .clk   (clk),
                    .en    (en),
                    .n_in  (dv_n[gd][gl]),
                    .r_in  (dv_r[gd][gl]),
                    .q_in  (dv_q[gd][gl]),
                    .d_in  ({dv_root[gd], 1'b0}),
                    .n_reg (dv_n[gd+1][gl]),
                    .r_reg (dv_r[gd+1][gl]),
                    .q_reg (dv_q[gd+1][gl])
                );
            end
        end
    endgenerate

    // saturate a magnitude with its sign to the output range
    function automatic logic [DW-1:0] sat_mag(input logic [NW-1:0] q, input logic neg);
        logic [DW-1:0] low;
        low = q[DW-1:0];
        if (!neg)
        begin
            return (q >= LIM) ? {1'b0, {(DW-1){1'b1}}} : low;
        end
        return (q > LIM) ? {1'b1, {(DW-1){1'b0}}} : DW'(-low);
    endfunction

    // place the half root and the quotients
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sat[k] = sat_mag(dv_q[NW][k], dv_ctl[NW].neg[k]);
        end
        half_sum = {1'b0, dv_root[NW]} + 1'b1;
        half     = sat_mag(NW'(half_sum[SW:1]), 1'b0);
        case (dv_ctl[NW].sel)
            SEL_W:
            begin
                w_next = half;   x_next = sat[0]; y_next = sat[1]; z_next = sat[2];
            end
            SEL_X:
            begin
                w_next = sat[0]; x_next = half;   y_next = sat[1]; z_next = sat[2];
            end
            SEL_Y:
            begin
                w_next = sat[0]; x_next = sat[2]; y_next = half;   z_next = sat[1];
            end
            default:
            begin
                w_next = sat[0]; x_next = sat[1]; y_next = sat[2]; z_next = half;
            end
        endcase
        if (dv_ctl[NW].bad)
        begin
            w_next = '0;
            x_next = '0;
            y_next = '0;
            z_next = '0;
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_ctl[NW].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg   <= w_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            bad_reg <= dv_ctl[NW].bad;
        end
    end

    assign quat.valid   = out_valid_reg;
    assign quat.quat_w  = w_reg;
    assign quat.quat_x  = x_reg;
    assign quat.quat_y  = y_reg;
    assign quat.quat_z  = z_reg;
    assign quat.invalid = bad_reg;

    `RMQ_ASSERT_IMP(a_bad_zero, quat.valid && quat.invalid, (quat.quat_w == '0) && (quat.quat_x == '0) && (quat.quat_y == '0) && (quat.quat_z == '0))
    `RMQ_ASSERT_IMP(a_stall_blocks, quat.valid && !quat.ready, !mat.ready)
    `RMQ_ASSERT_NXT(a_accept_enters, mat.valid && mat.ready, sq_ctl[0].valid)
    `RMQ_ASSERT_IMP(a_root_rem, sq_ctl[SW].valid && !sq_ctl[SW].bad, sq_r[SW] <= {1'b0, sq_q[SW], 1'b0})
endmodule
`default_nettype wire

/* verif/tb.sv */
module tb;

    localparam int DW = 16;
    localparam int FB = 14;
    localparam int LATENCY = 52;

    typedef struct packed {
        logic [DW-1:0] w;
        logic [DW-1:0] x;
        logic [DW-1:0] y;
        logic [DW-1:0] z;
        logic          bad;
    } quat_t;

    typedef logic [9*DW-1:0] matrix_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   errors = 0;
    bit   all_sent = 1'b0;
    bit   hold_long = 1'b0;

    rmq_mat_if  #(.DW(DW)) mat ();
    rmq_quat_if #(.DW(DW)) quat ();

    rotation_matrix_to_quaternion #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .mat  (mat.sink),
        .quat (quat.source)
    );

    always #5 clk = ~clk;

    matrix_t pending_mats[$];
    quat_t   expected_quats[$];

    function automatic longint elem(matrix_t mx, int r, int c);
        logic signed [DW-1:0] e;
        e = mx[(r*3+c)*DW +: DW];
        return longint'(e);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned a);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > a)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (a >= res + bitv)
            begin
                a -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint half_div(longint n, longint unsigned root);
        longint unsigned mag;
        longint unsigned q;
        mag = (n < 0) ? longint'(-n) : n;
        q = ((mag << FB) + root) / (root << 1);
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [DW-1:0] clamp(longint v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[DW-1:0];
    endfunction

    // compute the quaternion for one matrix
    function automatic quat_t matrix_to_quat(matrix_t mx);
        longint m[3][3];
        longint trace, arg, w;
        longint v[3];
        longint unsigned root;
        int i, j, k;
        int succ[3];
        quat_t q;
        succ = '{1, 2, 0};
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                m[r][c] = elem(mx, r, c);
        trace = m[0][0] + m[1][1] + m[2][2];
        i = 0;
        v = '{0, 0, 0};
        q = '0;
        if (trace > 0)
            arg = trace + (64'sd1 << FB);
        else
        begin
            if (m[1][1] > m[0][0])
                i = 1;
            if (m[2][2] > m[i][i])
                i = 2;
            j = succ[i];
            k = succ[j];
            arg = m[i][i] - m[j][j] - m[k][k] + (64'sd1 << FB);
        end
        if (arg <= 0)
        begin
            q.bad = 1'b1;
            return q;
        end
        root = int_sqrt(longint'(arg) << FB);
        if (root == 0)
        begin
            q.bad = 1'b1;
            return q;
        end
        if (trace > 0)
        begin
            w = longint'((root + 1) >> 1);
            v[0] = half_div(m[2][1] - m[1][2], root);
            v[1] = half_div(m[0][2] - m[2][0], root);
            v[2] = half_div(m[1][0] - m[0][1], root);
        end
        else
        begin
            v[i] = longint'((root + 1) >> 1);
            w = half_div(m[k][j] - m[j][k], root);
            v[j] = half_div(m[j][i] + m[i][j], root);
            v[k] = half_div(m[k][i] + m[i][k], root);
        end
        q.w = clamp(w);
        q.x = clamp(v[0]);
        q.y = clamp(v[1]);
        q.z = clamp(v[2]);
        return q;
    endfunction

    function automatic matrix_t diag_mat(int a, int b, int c, int off);
        matrix_t mx;
        for (int e = 0; e < 9; e++)
            mx[e*DW +: DW] = DW'(off * (e + 1));
        mx[0*DW +: DW] = DW'(a);
        mx[4*DW +: DW] = DW'(b);
        mx[8*DW +: DW] = DW'(c);
        return mx;
    endfunction

    function automatic matrix_t rand_mat();
        matrix_t mx;
        int mode;
        mode = $urandom_range(0, 9);
        for (int e = 0; e < 9; e++)
        begin
            if (mode < 6)
                mx[e*DW +: DW] = DW'($urandom_range(0, 32768) - 16384);
            else if (mode < 8)
                mx[e*DW +: DW] = DW'($urandom_range(0, 4096) - 2048);
            else
                mx[e*DW +: DW] = DW'($urandom);
        end
        return mx;
    endfunction

    // fill the stimulus queue
    initial
    begin
        pending_mats.push_back('0);
        pending_mats.push_back(diag_mat(16384, 16384, 16384, 0));
        pending_mats.push_back(diag_mat(16384, -16384, -16384, 0));
        pending_mats.push_back(diag_mat(-16384, 16384, -16384, 0));
        pending_mats.push_back(diag_mat(-16384, -16384, 16384, 0));
        pending_mats.push_back(diag_mat(-16384, -16384, -16384, 0));
        pending_mats.push_back(diag_mat(0, 0, 0, 100));
        pending_mats.push_back(diag_mat(5, 5, 5, 7));
        pending_mats.push_back(diag_mat(-5, 5, 5, 3));
        pending_mats.push_back(diag_mat(-9, -3, -3, 11));
        pending_mats.push_back(diag_mat(32767, 32767, 32767, 32767));
        pending_mats.push_back(diag_mat(-32768, -32768, -32768, -32768));
        pending_mats.push_back(diag_mat(32767, -32768, -32768, 1));
        pending_mats.push_back(diag_mat(-32768, -32768, 32767, -1));
        pending_mats.push_back(diag_mat(-16384, 0, 0, 0));
        pending_mats.push_back({9{16'h8000}});
        pending_mats.push_back({9{16'h7fff}});
        pending_mats.push_back({9{16'hffff}});
        pending_mats.push_back(diag_mat(-1, 0, 0, 16384));
        pending_mats.push_back(diag_mat(0, -1, 0, -20000));
        for (int n = 0; n < 1050; n++)
            pending_mats.push_back(rand_mat());
    end

    // drive matrix words from the queue
    int send_wait = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat.valid <= 1'b0;
            {mat.m_r0c0, mat.m_r0c1, mat.m_r0c2, mat.m_r1c0, mat.m_r1c1,
             mat.m_r1c2, mat.m_r2c0, mat.m_r2c1, mat.m_r2c2} <= '0;
            send_wait <= $urandom_range(0, 9);
        end
        else if (!mat.valid || mat.ready)
        begin
            if (mat.valid)
                expected_quats.push_back(matrix_to_quat({mat.m_r2c2, mat.m_r2c1,
                    mat.m_r2c0, mat.m_r1c2, mat.m_r1c1, mat.m_r1c0, mat.m_r0c2,
                    mat.m_r0c1, mat.m_r0c0}));
            if (pending_mats.size() == 0)
            begin
                mat.valid <= 1'b0;
                all_sent <= 1'b1;
            end
            else if (send_wait > 0 && !hold_long)
            begin
                mat.valid <= 1'b0;
                send_wait <= send_wait - 1;
            end
            else
            begin
                matrix_t mx;
                mx = pending_mats.pop_front();
                {mat.m_r2c2, mat.m_r2c1, mat.m_r2c0, mat.m_r1c2, mat.m_r1c1,
                 mat.m_r1c0, mat.m_r0c2, mat.m_r0c1, mat.m_r0c0} <= mx;
                mat.valid <= 1'b1;
                send_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
            end
        end
    end

    // stall the output, with one long hold-off to fill the chain
    int recv_wait = 0;
    int stall_count = 0;
    int accepted = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat.ready <= 1'b0;
            recv_wait <= 0;
            hold_long <= 1'b0;
        end
        else if (accepted >= 300 && stall_count < 200)
        begin
            hold_long <= 1'b1;
            quat.ready <= 1'b0;
            stall_count <= stall_count + 1;
        end
        else
        begin
            hold_long <= 1'b0;
            if (recv_wait > 0)
            begin
                quat.ready <= 1'b0;
                recv_wait <= recv_wait - 1;
            end
            else
            begin
                quat.ready <= 1'b1;
                if (quat.valid && quat.ready)
                    recv_wait <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : 0;
            end
        end
    end

    // check each quaternion word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && quat.valid && quat.ready)
        begin
            quat_t exp_q;
            accepted <= accepted + 1;
            if (expected_quats.size() == 0)
            begin
                $error("unexpected quaternion word");
                errors++;
            end
            else
            begin
                exp_q = expected_quats.pop_front();
                if (quat.quat_w !== exp_q.w)
                begin
                    $error("quat_w expected %h actual %h", exp_q.w, quat.quat_w);
                    errors++;
                end
                if (quat.quat_x !== exp_q.x)
                begin
                    $error("quat_x expected %h actual %h", exp_q.x, quat.quat_x);
                    errors++;
                end
                if (quat.quat_y !== exp_q.y)
                begin
                    $error("quat_y expected %h actual %h", exp_q.y, quat.quat_y);
                    errors++;
                end
                if (quat.quat_z !== exp_q.z)
                begin
                    $error("quat_z expected %h actual %h", exp_q.z, quat.quat_z);
                    errors++;
                end
                if (quat.invalid !== exp_q.bad)
                begin
                    $error("invalid expected %b actual %b", exp_q.bad, quat.invalid);
                    errors++;
                end
            end
        end
    end

    // reset, then wait for the chain to drain
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        wait (all_sent);
        wait (expected_quats.size() == 0);
        repeat (LATENCY * 2) @(posedge clk);
        if (errors == 0 && expected_quats.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
